/* rtl/pct_pkg.sv */
// Shared types and constants for the preprocessor character tokenizer.
// Holds the item and result structs, token class codes and character codes.
// No dependencies.
package pct_pkg;

	localparam int unsigned NumWidth = 31;
	localparam logic [NumWidth-1:0] SAT_MAX = {NumWidth{1'b1}};

	// Token class codes.
	localparam logic [3:0] CLS_SKIP      = 4'd0;
	localparam logic [3:0] CLS_DIRECTIVE = 4'd1;
	localparam logic [3:0] CLS_IDENT     = 4'd2;
	localparam logic [3:0] CLS_INTEGER   = 4'd3;
	localparam logic [3:0] CLS_STRING    = 4'd4;
	localparam logic [3:0] CLS_COMMAND   = 4'd5;
	localparam logic [3:0] CLS_LPAREN    = 4'd6;
	localparam logic [3:0] CLS_RPAREN    = 4'd7;
	localparam logic [3:0] CLS_OPERATOR  = 4'd8;
	localparam logic [3:0] CLS_EOF       = 4'd9;
	localparam logic [3:0] CLS_ENDEXPR   = 4'd10;
	localparam logic [3:0] CLS_BAD       = 4'd11;
	localparam logic [3:0] CLS_OPEN_STR  = 4'd12;

	// Character codes.
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_input;
	} tok_item_t;

	typedef struct packed {
		logic [7:0]          out_char;
		logic [3:0]          token_class;
		logic                first_of_token;
		logic                last_of_token;
		logic [NumWidth-1:0] number_value;
		logic                number_overflow;
		logic                last_result;
	} tok_result_t;

endpackage

/* rtl/preprocessor_char_tokenizer.sv */
// Preprocessor character tokenizer, top level.
// Depends on pct_pkg for the item/result structs, class codes and character codes.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    pct_pkg::tok_item_t
// out      output     out_valid/out_ready  pct_pkg::tok_result_t
// cfg      input      cfg_valid/cfg_ready  expr_mode bit
//
// One byte item is taken per cycle while in_ready is high; its result (for the byte held before it) is
// registered and shown in the next cycle.
// An end-of-input item with a held byte gives two results; the input is then
// held off while the end marker moves into the output register.
// Reset clears the held byte and all scanner state; no clearing pass is needed.
// When out_ready is low and the output register is full, in_ready drops.
module preprocessor_char_tokenizer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  pct_pkg::tok_item_t      in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output pct_pkg::tok_result_t    out_data,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_data
);

	typedef enum logic [3:0] {
		LX_IDLE, LX_IDENT, LX_DIRECTIVE, LX_NUMBER, LX_STRING, LX_LINE,
		LX_BLOCK_OPEN, LX_BLOCK, LX_BLOCK_CLOSE, LX_OP2
	} lex_state_t;

	function automatic logic is_num_char(input logic [7:0] c);
		return c >= pct_pkg::CH_0 && c <= pct_pkg::CH_9;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= pct_pkg::CH_LA && c <= pct_pkg::CH_LZ) ||
		       (c >= pct_pkg::CH_UA && c <= pct_pkg::CH_UZ);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_letter(c) || is_num_char(c) || c == pct_pkg::CH_UNDER;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == pct_pkg::CH_SPACE || c == pct_pkg::CH_TAB || c == pct_pkg::CH_NL ||
		       c == pct_pkg::CH_CR || c == pct_pkg::CH_VT || c == pct_pkg::CH_FF;
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return c == pct_pkg::CH_PLUS || c == pct_pkg::CH_MINUS || c == pct_pkg::CH_STAR ||
		       c == pct_pkg::CH_SLASH || c == pct_pkg::CH_PCT || c == pct_pkg::CH_AMP ||
		       c == pct_pkg::CH_PIPE || c == pct_pkg::CH_CARET || c == pct_pkg::CH_TILDE ||
		       c == pct_pkg::CH_BANG || c == pct_pkg::CH_LT || c == pct_pkg::CH_GT ||
		       c == pct_pkg::CH_EQ;
	endfunction

	function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
		return (a == pct_pkg::CH_AMP && b == pct_pkg::CH_AMP) ||
		       (a == pct_pkg::CH_PIPE && b == pct_pkg::CH_PIPE) ||
		       (a == pct_pkg::CH_EQ && b == pct_pkg::CH_EQ) ||
		       (a == pct_pkg::CH_BANG && b == pct_pkg::CH_EQ) ||
		       (a == pct_pkg::CH_LT && b == pct_pkg::CH_EQ) ||
		       (a == pct_pkg::CH_GT && b == pct_pkg::CH_EQ) ||
		       (a == pct_pkg::CH_LT && b == pct_pkg::CH_LT) ||
		       (a == pct_pkg::CH_GT && b == pct_pkg::CH_GT);
	endfunction

	function automatic logic is_command(input logic [7:0] c);
		return c == pct_pkg::CH_PLUS || c == pct_pkg::CH_MINUS || c == pct_pkg::CH_LT ||
		       c == pct_pkg::CH_GT || c == pct_pkg::CH_LBRACK || c == pct_pkg::CH_RBRACK ||
		       c == pct_pkg::CH_DOT || c == pct_pkg::CH_COMMA;
	endfunction

	localparam int unsigned NW = pct_pkg::NumWidth;

	// Control and state registers.
	lex_state_t           lex_q;
	logic [7:0]           held_q;
	logic                 held_valid_q;
	logic [NW-1:0]        acc_q;
	logic                 sat_q;
	logic                 expr_mode_q;
	logic                 out_valid_q;
	pct_pkg::tok_result_t out_q;
	logic                 pend_q;
	logic                 pend_expr_q;

	logic in_fire;
	logic out_free;
	logic has_n;
	logic [7:0] n;
	logic word_next;
	logic digit_next;

	// Classification of the held byte.
	lex_state_t     nxt_lex;
	logic [NW-1:0]  nxt_acc;
	logic           nxt_sat;
	logic [3:0]     r_cls;
	logic           r_first;
	logic           r_last;
	logic [NW-1:0]  r_val;
	logic           r_ov;
	logic           take_idle;

	// Between-token path results.
	lex_state_t     idle_lex;
	logic [3:0]     idle_cls;
	logic           idle_first;
	logic           idle_last;
	logic           idle_num;
	logic           two_byte;

	logic [3:0]     digit_h;
	logic [NW+3:0]  acc_x10;
	logic [NW-1:0]  acc_add;
	logic           acc_sat;

	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !pend_q && out_free;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign has_n      = !in_data.end_of_input;
	assign n          = in_data.in_char;
	assign word_next  = has_n && is_word(n);
	assign digit_next = has_n && is_num_char(n);
	assign two_byte   = has_n && is_pair(held_q, n);

	// Decimal accumulate: acc * 10 + digit as two shifts and two adds.
	assign digit_h = held_q[3:0] - pct_pkg::CH_0[3:0];
	assign acc_x10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {{NW{1'b0}}, digit_h};
	assign acc_sat = sat_q || (acc_x10 > {4'b0, pct_pkg::SAT_MAX});
	assign acc_add = acc_sat ? pct_pkg::SAT_MAX : acc_x10[NW-1:0];

	always_comb begin
		idle_lex   = LX_IDLE;
		idle_cls   = pct_pkg::CLS_BAD;
		idle_first = 1'b1;
		idle_last  = 1'b1;
		idle_num   = 1'b0;
		priority if (held_q == pct_pkg::CH_SLASH && has_n && n == pct_pkg::CH_SLASH) begin
			idle_lex   = LX_LINE;
			idle_cls   = pct_pkg::CLS_SKIP;
			idle_first = 1'b0;
			idle_last  = 1'b0;
		end else if (held_q == pct_pkg::CH_SLASH && has_n && n == pct_pkg::CH_STAR) begin
			idle_lex   = LX_BLOCK_OPEN;
			idle_cls   = pct_pkg::CLS_SKIP;
			idle_first = 1'b0;
			idle_last  = 1'b0;
		end else if (expr_mode_q && held_q == pct_pkg::CH_NL) begin
			idle_cls = pct_pkg::CLS_ENDEXPR;
		end else if (is_space(held_q)) begin
			idle_cls   = pct_pkg::CLS_SKIP;
			idle_first = 1'b0;
			idle_last  = 1'b0;
		end else if (is_num_char(held_q)) begin
			idle_cls  = pct_pkg::CLS_INTEGER;
			idle_num  = 1'b1;
			idle_last = !digit_next;
			if (digit_next) begin
				idle_lex = LX_NUMBER;
			end
		end else if (is_letter(held_q) || held_q == pct_pkg::CH_UNDER) begin
			idle_cls  = pct_pkg::CLS_IDENT;
			idle_last = !word_next;
			if (word_next) begin
				idle_lex = LX_IDENT;
			end
		end else if (held_q == pct_pkg::CH_LPAREN) begin
			idle_cls = pct_pkg::CLS_LPAREN;
		end else if (held_q == pct_pkg::CH_RPAREN) begin
			idle_cls = pct_pkg::CLS_RPAREN;
		end else if (expr_mode_q) begin
			if (is_op(held_q)) begin
				idle_cls  = pct_pkg::CLS_OPERATOR;
				idle_last = !two_byte;
				if (two_byte) begin
					idle_lex = LX_OP2;
				end
			end
		end else begin
			priority if (held_q == pct_pkg::CH_HASH) begin
				idle_cls  = pct_pkg::CLS_DIRECTIVE;
				idle_last = !word_next;
				if (word_next) begin
					idle_lex = LX_DIRECTIVE;
				end
			end else if (held_q == pct_pkg::CH_QUOTE) begin
				if (has_n) begin
					idle_cls  = pct_pkg::CLS_STRING;
					idle_last = 1'b0;
					idle_lex  = LX_STRING;
				end else begin
					idle_cls = pct_pkg::CLS_OPEN_STR;
				end
			end else if (is_command(held_q)) begin
				idle_cls = pct_pkg::CLS_COMMAND;
			end else begin
				idle_cls = pct_pkg::CLS_BAD;
			end
		end
	end

	always_comb begin
		nxt_lex   = lex_q;
		nxt_acc   = acc_q;
		nxt_sat   = sat_q;
		r_cls     = pct_pkg::CLS_SKIP;
		r_first   = 1'b0;
		r_last    = 1'b0;
		r_val     = '0;
		r_ov      = 1'b0;
		take_idle = 1'b0;
		unique case (lex_q)
			LX_IDENT, LX_DIRECTIVE: begin
				r_cls  = (lex_q == LX_DIRECTIVE) ? pct_pkg::CLS_DIRECTIVE : pct_pkg::CLS_IDENT;
				r_last = !word_next;
				if (!word_next) begin
					nxt_lex = LX_IDLE;
				end
			end
			LX_NUMBER: begin
				if (is_num_char(held_q)) begin
					nxt_acc = acc_add;
					nxt_sat = acc_sat;
				end
				r_cls  = pct_pkg::CLS_INTEGER;
				r_last = !digit_next;
				r_val  = nxt_acc;
				r_ov   = nxt_sat;
				if (!digit_next) begin
					nxt_lex = LX_IDLE;
				end
			end
			LX_STRING: begin
				if (held_q == pct_pkg::CH_QUOTE) begin
					nxt_lex = LX_IDLE;
					r_cls   = pct_pkg::CLS_STRING;
					r_last  = 1'b1;
				end else if (!has_n) begin
					nxt_lex = LX_IDLE;
					r_cls   = pct_pkg::CLS_OPEN_STR;
					r_last  = 1'b1;
				end else begin
					r_cls = pct_pkg::CLS_STRING;
				end
			end
			LX_LINE: begin
				// The newline that ends a line comment is classified as between tokens.
				take_idle = (held_q == pct_pkg::CH_NL);
			end
			LX_BLOCK_OPEN: begin
				nxt_lex = LX_BLOCK;
			end
			LX_BLOCK: begin
				if (held_q == pct_pkg::CH_STAR && has_n && n == pct_pkg::CH_SLASH) begin
					nxt_lex = LX_BLOCK_CLOSE;
				end
			end
			LX_BLOCK_CLOSE: begin
				nxt_lex = LX_IDLE;
			end
			LX_OP2: begin
				nxt_lex = LX_IDLE;
				r_cls   = pct_pkg::CLS_OPERATOR;
				r_last  = 1'b1;
			end
			default: begin
				take_idle = 1'b1;
			end
		endcase
		if (take_idle) begin
			nxt_lex = idle_lex;
			r_cls   = idle_cls;
			r_first = idle_first;
			r_last  = idle_last;
			if (idle_num) begin
				nxt_acc = {{(NW-4){1'b0}}, digit_h};
				nxt_sat = 1'b0;
				r_val   = nxt_acc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q        <= LX_IDLE;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			acc_q        <= '0;
			sat_q        <= 1'b0;
			expr_mode_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			pend_q       <= 1'b0;
			pend_expr_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				expr_mode_q <= cfg_data;
			end
			if (pend_q) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
					out_q       <= '{out_char: 8'd0,
						token_class: pend_expr_q ? pct_pkg::CLS_ENDEXPR : pct_pkg::CLS_EOF,
						first_of_token: 1'b1, last_of_token: 1'b1, number_value: '0,
						number_overflow: 1'b0, last_result: 1'b1};
					pend_q      <= 1'b0;
				end
			end else if (in_fire) begin
				if (in_data.end_of_input) begin
					// End of stream: flush the held byte, if any, then the end marker.
					lex_q        <= LX_IDLE;
					held_q       <= '0;
					held_valid_q <= 1'b0;
					acc_q        <= '0;
					sat_q        <= 1'b0;
					out_valid_q  <= 1'b1;
					if (held_valid_q) begin
						out_q       <= '{out_char: held_q, token_class: r_cls,
							first_of_token: r_first, last_of_token: r_last,
							number_value: r_val, number_overflow: r_ov, last_result: 1'b0};
						pend_q      <= 1'b1;
						pend_expr_q <= expr_mode_q;
					end else begin
						out_q <= '{out_char: 8'd0,
							token_class: expr_mode_q ? pct_pkg::CLS_ENDEXPR : pct_pkg::CLS_EOF,
							first_of_token: 1'b1, last_of_token: 1'b1, number_value: '0,
							number_overflow: 1'b0, last_result: 1'b1};
					end
				end else begin
					held_q       <= in_data.in_char;
					held_valid_q <= 1'b1;
					out_valid_q  <= held_valid_q;
					if (held_valid_q) begin
						lex_q       <= nxt_lex;
						acc_q       <= nxt_acc;
						sat_q       <= nxt_sat;
						out_q       <= '{out_char: held_q, token_class: r_cls,
							first_of_token: r_first, last_of_token: r_last,
							number_value: r_val, number_overflow: r_ov, last_result: 1'b1};
					end
				end
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A pending end marker always sits behind a result in the output register.
	assert property (@(posedge clk) disable iff (!arst_n) pend_q |-> out_valid_q)
		else $error("end marker pending with empty output register");

	// After an end-of-input transaction the scanner is back at its start state.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.end_of_input) |=> (!held_valid_q && lex_q == LX_IDLE && !sat_q))
		else $error("scanner state not cleared after end of input");

	// Skipped bytes never carry token boundary marks.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.token_class == pct_pkg::CLS_SKIP)
		|-> (!out_q.first_of_token && !out_q.last_of_token))
		else $error("skipped byte marked as token boundary");

	// A saturated integer always reads as the largest value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.number_overflow) |-> (out_q.number_value == pct_pkg::SAT_MAX))
		else $error("overflow flag without saturated value");

	// A result flagged as not last is always followed by the pending end marker.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.last_result) |-> pend_q)
		else $error("non-final result without a following marker");

endmodule

/* test/testbench.sv */
// Self-checking testbench for the preprocessor character tokenizer.
// Depends on pct_pkg and the preprocessor_char_tokenizer top level; predicts every
// result from its own tokenizer model and checks it against the block's output.
module testbench;

	typedef enum logic [3:0] {
		SC_IDLE, SC_IDENT, SC_DIRECTIVE, SC_NUMBER, SC_STRING, SC_LINE,
		SC_BLOCK_OPEN, SC_BLOCK, SC_BLOCK_CLOSE, SC_OP2
	} scan_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	pct_pkg::tok_item_t   in_data = '0;
	logic                 out_ready = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_data = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic                 cfg_ready;
	pct_pkg::tok_result_t out_data;

	// Own copy of the tokenizer state and its mode register.
	logic          expr_mode_q = 1'b0;
	scan_t         scan_q = SC_IDLE;
	logic [7:0]    held_byte = '0;
	logic          held_full = 1'b0;
	logic [30:0]   number_sum = '0;
	logic          number_sat = 1'b0;

	pct_pkg::tok_result_t expected_q[$];
	int          mismatches = 0;
	int          bytes_sent = 0;
	logic        calm = 1'b0;

	preprocessor_char_tokenizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic is_num_char(logic [7:0] c);
		return c >= pct_pkg::CH_0 && c <= pct_pkg::CH_9;
	endfunction

	function automatic logic is_word_char(logic [7:0] c);
		return (c >= pct_pkg::CH_LA && c <= pct_pkg::CH_LZ) ||
			(c >= pct_pkg::CH_UA && c <= pct_pkg::CH_UZ) ||
			is_num_char(c) || c == pct_pkg::CH_UNDER;
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return c == pct_pkg::CH_SPACE || c == pct_pkg::CH_TAB || c == pct_pkg::CH_CR ||
			c == pct_pkg::CH_NL || c == pct_pkg::CH_VT || c == pct_pkg::CH_FF;
	endfunction

	function automatic logic is_operator(logic [7:0] c);
		return c == pct_pkg::CH_PLUS || c == pct_pkg::CH_MINUS || c == pct_pkg::CH_STAR ||
			c == pct_pkg::CH_SLASH || c == pct_pkg::CH_PCT || c == pct_pkg::CH_AMP ||
			c == pct_pkg::CH_PIPE || c == pct_pkg::CH_CARET || c == pct_pkg::CH_TILDE ||
			c == pct_pkg::CH_BANG || c == pct_pkg::CH_LT || c == pct_pkg::CH_GT ||
			c == pct_pkg::CH_EQ;
	endfunction

	function automatic logic is_op_pair(logic [7:0] a, logic [7:0] b);
		return (a == pct_pkg::CH_AMP && b == pct_pkg::CH_AMP) ||
			(a == pct_pkg::CH_PIPE && b == pct_pkg::CH_PIPE) ||
			(a == pct_pkg::CH_EQ && b == pct_pkg::CH_EQ) ||
			(a == pct_pkg::CH_BANG && b == pct_pkg::CH_EQ) ||
			(a == pct_pkg::CH_LT && b == pct_pkg::CH_EQ) ||
			(a == pct_pkg::CH_GT && b == pct_pkg::CH_EQ) ||
			(a == pct_pkg::CH_LT && b == pct_pkg::CH_LT) ||
			(a == pct_pkg::CH_GT && b == pct_pkg::CH_GT);
	endfunction

	function automatic logic is_cmd(logic [7:0] c);
		return c == pct_pkg::CH_PLUS || c == pct_pkg::CH_MINUS || c == pct_pkg::CH_LT ||
			c == pct_pkg::CH_GT || c == pct_pkg::CH_LBRACK || c == pct_pkg::CH_RBRACK ||
			c == pct_pkg::CH_DOT || c == pct_pkg::CH_COMMA;
	endfunction

	function automatic pct_pkg::tok_result_t tag(logic [7:0] c, logic [3:0] cls, logic f,
			logic l, logic [30:0] v, logic ov);
		pct_pkg::tok_result_t r;
		r.out_char = c;
		r.token_class = cls;
		r.first_of_token = f;
		r.last_of_token = l;
		r.number_value = v;
		r.number_overflow = ov;
		r.last_result = 1'b0;
		return r;
	endfunction

	// Tags the held byte h; has_n is low when end of input follows it.
	function pct_pkg::tok_result_t tag_held_byte(logic [7:0] h, logic has_n, logic [7:0] n);
		logic        word_nx;
		logic        digit_nx;
		logic        pair_nx;
		logic [3:0]  cls;
		logic [34:0] sum;
		word_nx = has_n && is_word_char(n);
		digit_nx = has_n && is_num_char(n);
		case (scan_q)
			SC_IDENT, SC_DIRECTIVE: begin
				cls = (scan_q == SC_DIRECTIVE) ? pct_pkg::CLS_DIRECTIVE : pct_pkg::CLS_IDENT;
				if (!word_nx) scan_q = SC_IDLE;
				return tag(h, cls, 1'b0, !word_nx, '0, 1'b0);
			end
			SC_NUMBER: begin
				if (is_num_char(h)) begin
					sum = {4'b0, number_sum} * 35'd10 + 35'(h[3:0]);
					if (number_sat || sum > 35'(pct_pkg::SAT_MAX)) begin
						number_sum = pct_pkg::SAT_MAX;
						number_sat = 1'b1;
					end else begin
						number_sum = sum[30:0];
					end
				end
				if (!digit_nx) scan_q = SC_IDLE;
				return tag(h, pct_pkg::CLS_INTEGER, 1'b0, !digit_nx, number_sum, number_sat);
			end
			SC_STRING: begin
				if (h == pct_pkg::CH_QUOTE) begin
					scan_q = SC_IDLE;
					return tag(h, pct_pkg::CLS_STRING, 1'b0, 1'b1, '0, 1'b0);
				end
				if (!has_n) begin
					scan_q = SC_IDLE;
					return tag(h, pct_pkg::CLS_OPEN_STR, 1'b0, 1'b1, '0, 1'b0);
				end
				return tag(h, pct_pkg::CLS_STRING, 1'b0, 1'b0, '0, 1'b0);
			end
			SC_LINE: begin
				// The newline that ends a line comment is classified as a fresh byte.
				if (h != pct_pkg::CH_NL) return tag(h, pct_pkg::CLS_SKIP, 1'b0, 1'b0, '0, 1'b0);
				scan_q = SC_IDLE;
			end
			SC_BLOCK_OPEN: begin
				scan_q = SC_BLOCK;
				return tag(h, pct_pkg::CLS_SKIP, 1'b0, 1'b0, '0, 1'b0);
			end
			SC_BLOCK: begin
				if (h == pct_pkg::CH_STAR && has_n && n == pct_pkg::CH_SLASH)
					scan_q = SC_BLOCK_CLOSE;
				return tag(h, pct_pkg::CLS_SKIP, 1'b0, 1'b0, '0, 1'b0);
			end
			SC_BLOCK_CLOSE: begin
				scan_q = SC_IDLE;
				return tag(h, pct_pkg::CLS_SKIP, 1'b0, 1'b0, '0, 1'b0);
			end
			SC_OP2: begin
				scan_q = SC_IDLE;
				return tag(h, pct_pkg::CLS_OPERATOR, 1'b0, 1'b1, '0, 1'b0);
			end
			default: begin
				scan_q = SC_IDLE;
			end
		endcase

		if (h == pct_pkg::CH_SLASH && has_n && n == pct_pkg::CH_SLASH) begin
			scan_q = SC_LINE;
			return tag(h, pct_pkg::CLS_SKIP, 1'b0, 1'b0, '0, 1'b0);
		end
		if (h == pct_pkg::CH_SLASH && has_n && n == pct_pkg::CH_STAR) begin
			scan_q = SC_BLOCK_OPEN;
			return tag(h, pct_pkg::CLS_SKIP, 1'b0, 1'b0, '0, 1'b0);
		end
		if (expr_mode_q && h == pct_pkg::CH_NL)
			return tag(h, pct_pkg::CLS_ENDEXPR, 1'b1, 1'b1, '0, 1'b0);
		if (is_blank(h)) return tag(h, pct_pkg::CLS_SKIP, 1'b0, 1'b0, '0, 1'b0);
		if (is_num_char(h)) begin
			number_sum = 31'(h[3:0]);
			number_sat = 1'b0;
			if (digit_nx) scan_q = SC_NUMBER;
			return tag(h, pct_pkg::CLS_INTEGER, 1'b1, !digit_nx, number_sum, 1'b0);
		end
		if (is_word_char(h)) begin
			if (word_nx) scan_q = SC_IDENT;
			return tag(h, pct_pkg::CLS_IDENT, 1'b1, !word_nx, '0, 1'b0);
		end
		if (h == pct_pkg::CH_LPAREN) return tag(h, pct_pkg::CLS_LPAREN, 1'b1, 1'b1, '0, 1'b0);
		if (h == pct_pkg::CH_RPAREN) return tag(h, pct_pkg::CLS_RPAREN, 1'b1, 1'b1, '0, 1'b0);
		if (expr_mode_q) begin
			if (is_operator(h)) begin
				pair_nx = has_n && is_op_pair(h, n);
				if (pair_nx) scan_q = SC_OP2;
				return tag(h, pct_pkg::CLS_OPERATOR, 1'b1, !pair_nx, '0, 1'b0);
			end
		end else begin
			if (h == pct_pkg::CH_HASH) begin
				if (word_nx) scan_q = SC_DIRECTIVE;
				return tag(h, pct_pkg::CLS_DIRECTIVE, 1'b1, !word_nx, '0, 1'b0);
			end
			if (h == pct_pkg::CH_QUOTE) begin
				if (has_n) begin
					scan_q = SC_STRING;
					return tag(h, pct_pkg::CLS_STRING, 1'b1, 1'b0, '0, 1'b0);
				end
				return tag(h, pct_pkg::CLS_OPEN_STR, 1'b1, 1'b1, '0, 1'b0);
			end
			if (is_cmd(h)) return tag(h, pct_pkg::CLS_COMMAND, 1'b1, 1'b1, '0, 1'b0);
		end
		return tag(h, pct_pkg::CLS_BAD, 1'b1, 1'b1, '0, 1'b0);
	endfunction

	task automatic queue_expected_tags(input pct_pkg::tok_item_t it);
		pct_pkg::tok_result_t r;
		if (it.end_of_input) begin
			if (held_full) begin
				r = tag_held_byte(held_byte, 1'b0, 8'h00);
				expected_q = {expected_q, r};
			end
			r = tag(8'h00, expr_mode_q ? pct_pkg::CLS_ENDEXPR : pct_pkg::CLS_EOF,
				1'b1, 1'b1, '0, 1'b0);
			r.last_result = 1'b1;
			expected_q = {expected_q, r};
			held_full = 1'b0;
			held_byte = '0;
			scan_q = SC_IDLE;
			number_sum = '0;
			number_sat = 1'b0;
		end else begin
			if (held_full) begin
				r = tag_held_byte(held_byte, 1'b1, it.in_char);
				r.last_result = 1'b1;
				expected_q = {expected_q, r};
			end
			held_byte = it.in_char;
			held_full = 1'b1;
		end
	endtask

	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 18);
	end

	task automatic report(string why, pct_pkg::tok_result_t want, pct_pkg::tok_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s: expected char=%h class=%0d first=%b last=%b value=%0d ovf=%b end=%b",
				why, want.out_char, want.token_class, want.first_of_token,
				want.last_of_token, want.number_value, want.number_overflow,
				want.last_result);
			$display("    got      char=%h class=%0d first=%b last=%b value=%0d ovf=%b end=%b",
				got.out_char, got.token_class, got.first_of_token, got.last_of_token,
				got.number_value, got.number_overflow, got.last_result);
		end
	endtask

	always @(posedge clk) begin : check_results
		pct_pkg::tok_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected result", '0, out_data);
			end else begin
				want = expected_q[0];
				expected_q.delete(0);
				if (out_data.out_char !== want.out_char ||
						out_data.token_class !== want.token_class ||
						out_data.first_of_token !== want.first_of_token ||
						out_data.last_of_token !== want.last_of_token ||
						out_data.number_value !== want.number_value ||
						out_data.number_overflow !== want.number_overflow ||
						out_data.last_result !== want.last_result)
					report("result mismatch", want, out_data);
			end
		end
	end

	// Valid is only lowered in a cycle where no new transaction is offered.
	task automatic send_item(input pct_pkg::tok_item_t it);
		while (!calm && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		queue_expected_tags(it);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] c);
		pct_pkg::tok_item_t it;
		it.in_char = c;
		it.end_of_input = 1'b0;
		send_item(it);
	endtask

	task automatic send_eof();
		pct_pkg::tok_item_t it;
		it.in_char = 8'($urandom);
		it.end_of_input = 1'b1;
		send_item(it);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_expr_mode(input logic v);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		expr_mode_q = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	// One random piece of source text, mostly well-formed tokens.
	task automatic emit_fragment();
		int         len;
		int         idx;
		logic [7:0] c;
		string      pairs;
		pairs = "&&||==!=<=>=<<>>";
		case ($urandom_range(15))
			0, 1: begin
				send_byte(pick("abcxyzAQZ_"));
				len = $urandom_range(6);
				for (int i = 0; i < len; i++) send_byte(pick("aqzAMZ_0519"));
			end
			2: begin
				send_byte(pct_pkg::CH_HASH);
				len = $urandom_range(5);
				for (int i = 0; i < len; i++) send_byte(pick("adefinZ_07"));
			end
			3: begin
				len = ($urandom_range(7) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
				for (int i = 0; i < len; i++) send_byte(pick("0123456789"));
			end
			4: begin
				send_byte(pct_pkg::CH_QUOTE);
				len = $urandom_range(5);
				for (int i = 0; i < len; i++) begin
					c = 8'($urandom_range(255));
					send_byte(c == pct_pkg::CH_QUOTE ? pct_pkg::CH_SPACE : c);
				end
				if ($urandom_range(5) != 0) send_byte(pct_pkg::CH_QUOTE);
			end
			5: begin
				send_text("//");
				len = $urandom_range(6);
				for (int i = 0; i < len; i++) begin
					c = 8'($urandom_range(255));
					send_byte(c == pct_pkg::CH_NL ? pct_pkg::CH_SPACE : c);
				end
				send_byte(pct_pkg::CH_NL);
			end
			6: begin
				send_text("/*");
				len = $urandom_range(6);
				for (int i = 0; i < len; i++) send_byte(pick("ab*/ \n"));
				if ($urandom_range(5) != 0) send_text("*/");
			end
			7: begin
				idx = 2 * $urandom_range(7);
				send_byte(pairs[idx]);
				send_byte(pairs[idx + 1]);
			end
			8: send_byte(pick("+-*/%&|^~!<>="));
			9: send_byte(pick("()"));
			10: send_byte(pick("+-<>[].,"));
			11, 12: begin
				len = $urandom_range(1, 3);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(5))
						0: c = pct_pkg::CH_SPACE;
						1: c = pct_pkg::CH_TAB;
						2: c = pct_pkg::CH_CR;
						3: c = pct_pkg::CH_NL;
						4: c = pct_pkg::CH_VT;
						default: c = pct_pkg::CH_FF;
					endcase
					send_byte(c);
				end
			end
			13: send_byte(pct_pkg::CH_NL);
			14: send_byte(8'($urandom_range(255)));
			default: send_eof();
		endcase
	endtask

	task automatic test_normal_tokens();
		write_expr_mode(1'b0);
		send_text("#d _9 42\"s\"(+),");
		send_byte(8'hFF);
		send_byte(8'h00);
		send_eof();
	endtask

	task automatic test_comments_and_open_ends();
		drain_results();
		// Closed comments, then a string cut off by end of input.
		send_text("/*x*/ //c\n\"ab");
		send_eof();
		// A lone opening quote, then an end mark with no byte held.
		send_text("\"");
		send_eof();
		send_eof();
		// A block comment that never closes stays skipped.
		send_text("/*a");
		send_eof();
	endtask

	task automatic test_expression_mode();
		drain_results();
		write_expr_mode(1'b1);
		send_text("x<=(12)!\n~#\"/");
		send_eof();
		send_text("a//c\n");
		send_eof();
	endtask

	task automatic test_mode_switch_in_token();
		drain_results();
		write_expr_mode(1'b0);
		send_text("ab");
		drain_results();
		// The identifier started in normal mode runs on after the switch.
		write_expr_mode(1'b1);
		send_text("c==\n");
		send_eof();
	endtask

	task automatic test_random_streams();
		int goal;
		for (int ph = 0; ph < 8; ph++) begin
			drain_results();
			calm = (ph == 3);
			write_expr_mode(ph == 0 ? 1'b1 : ph == 1 ? 1'b0 : 1'($urandom_range(1)));
			goal = bytes_sent + 220;
			while (bytes_sent < goal) begin
				emit_fragment();
				// Hold the stream until everything outstanding has come out.
				if (ph == 5 && bytes_sent >= goal - 110 && bytes_sent < goal - 100)
					drain_results();
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_normal_tokens();
		test_comments_and_open_ends();
		test_expression_mode();
		test_mode_switch_in_token();
		test_random_streams();
		drain_results();
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

/* preprocessor_char_tokenizer.f */
rtl/pct_pkg.sv
rtl/preprocessor_char_tokenizer.sv
test/testbench.sv
